>>> hw/rtl/assert_macros.svh
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock, quiet in reset
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, sampled on the rising clock, quiet in reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/itx_pkg.sv
package itx_pkg;

    // largest number of results one query may return
    localparam int RESULT_CAP = 16;

    // job handed from the token buffer to the lookup engine
    typedef struct packed {
        logic       go;
        logic       query;
        logic [4:0] cap;
    } itx_job_t;

    // lookup engine states
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD   = 7'b0000010,
        S_CMP  = 7'b0000100,
        S_HIT  = 7'b0001000,
        S_MISS = 7'b0010000,
        S_PCHK = 7'b0100000,
        S_ORD  = 7'b1000000
    } itx_state_t;

endpackage

>>> hw/rtl/itx_tokbuf.sv
module itx_tokbuf #(
    parameter int TERM_BYTES   = 24,
    parameter int LINE_ID_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  logic                             op,
    input  logic [7:0]                       ch,
    input  logic                             last,
    input  logic [LINE_ID_BITS-1:0]          line_id,
    input  logic [4:0]                       max_lines,
    input  logic                             clr,
    output itx_pkg::itx_job_t                job,
    output logic [LINE_ID_BITS-1:0]          line,
    output logic [$clog2(TERM_BYTES)-1:0]    tok_len,
    output logic [(TERM_BYTES-1)*8-1:0]      tok_text
);
    import itx_pkg::*;

    localparam int TOK_MAX = TERM_BYTES - 1;
    localparam int LW      = $clog2(TERM_BYTES);

    logic [7:0]              buf_reg [TOK_MAX];
    logic [LW-1:0]           len_reg, len_next;
    itx_job_t                job_reg;
    logic [LINE_ID_BITS-1:0] line_reg;
    logic                    is_lo, is_up, is_dig, alnum, append, flush;
    logic [7:0]              lowered;

    // character classes
    always_comb
    begin
        is_lo   = (ch >= 8'h61) && (ch <= 8'h7a);
        is_up   = (ch >= 8'h41) && (ch <= 8'h5a);
        is_dig  = (ch >= 8'h30) && (ch <= 8'h39);
        alnum   = is_lo || is_up || is_dig;
        lowered = is_up ? ch + 8'd32 : ch;
        append  = accept && (op || alnum) && (len_reg < LW'(TOK_MAX));
        flush   = op ? last : (!alnum || last);
    end

    // token length
    always_comb
    begin
        len_next = len_reg;
        if (clr)
        begin
            len_next = '0;
        end
        else if (append)
        begin
            len_next = len_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            job_reg <= '0;
        end
        else
        begin
            len_reg    <= len_next;
            job_reg.go <= accept && flush;
            if (accept)
            begin
                job_reg.query <= op;
                job_reg.cap   <= max_lines;
            end
        end
    end

    // character bytes and line id of the item
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TOK_MAX; i++)
        begin
            if (append && (len_reg == LW'(i)))
            begin
                buf_reg[i] <= lowered;
            end
        end
        if (accept)
        begin
            line_reg <= line_id;
        end
    end

    always_comb
    begin
        for (int i = 0; i < TOK_MAX; i++)
        begin
            tok_text[i*8 +: 8] = buf_reg[i];
        end
    end

    assign job     = job_reg;
    assign line    = line_reg;
    assign tok_len = len_reg;

endmodule

>>> hw/rtl/itx_engine.sv
module itx_engine #(
    parameter int TERM_SLOTS    = 128,
    parameter int TERM_BYTES    = 24,
    parameter int POSTING_SLOTS = 16,
    parameter int LINE_ID_BITS  = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [4:0]                       min_len,
    input  itx_pkg::itx_job_t                job,
    input  logic [LINE_ID_BITS-1:0]          line,
    input  logic [$clog2(TERM_BYTES)-1:0]    tok_len,
    input  logic [(TERM_BYTES-1)*8-1:0]      tok_text,
    output logic                             busy,
    output logic                             clr,
    output logic                             strobe,
    output logic [LINE_ID_BITS-1:0]          hit_line,
    output logic [4:0]                       match_count,
    output logic [7:0]                       term_total,
    output logic                             final_res
);
    import itx_pkg::*;

    localparam int TOK_MAX = TERM_BYTES - 1;
    localparam int LW      = $clog2(TERM_BYTES);
    localparam int TXT_W   = TOK_MAX * 8;
    localparam int PCW     = $clog2(POSTING_SLOTS + 1);
    localparam int ROW_W   = LW + TXT_W + PCW;
    localparam int AW      = $clog2(TERM_SLOTS);
    localparam int CW      = $clog2(TERM_SLOTS + 1);
    localparam int PDEPTH  = TERM_SLOTS * POSTING_SLOTS;
    localparam int PAW     = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;

    // term rows: length, text, posting count
    logic [ROW_W-1:0]        tmem [TERM_SLOTS];
    logic [ROW_W-1:0]        t_q, t_wd;
    logic                    t_re, t_we;
    logic [AW-1:0]           t_ra, t_wa;
    // posting line ids, one block of slots per term
    logic [LINE_ID_BITS-1:0] pmem [PDEPTH];
    logic [LINE_ID_BITS-1:0] p_q, p_wd;
    logic                    p_re, p_we;
    logic [PAW-1:0]          p_ra, p_wa;

    itx_state_t              state_reg, state_next;
    logic [CW-1:0]           terms_reg, terms_next, scan_reg, scan_next;
    logic [AW-1:0]           idx_reg, idx_next;
    logic [4:0]              k_reg, k_next, j_reg, j_next, cap_reg, cap_next;
    logic                    query_reg, query_next;
    logic                    strobe_reg, strobe_next, fin_reg, fin_next;
    logic [LINE_ID_BITS-1:0] hit_reg, hit_next;
    logic [4:0]              cnt_reg, cnt_next;
    logic [7:0]              total_reg, total_next;

    logic [LW-1:0]           row_len;
    logic [PCW-1:0]          row_pc;
    logic                    row_hit;
    logic [6:0]              need, pc7, cap7, k7;

    function automatic logic [PAW-1:0] paddr(input logic [AW-1:0] term,
                                             input logic [6:0] slot);
        paddr = PAW'(term) * PAW'(POSTING_SLOTS) + PAW'(slot);
    endfunction

    // stored term against the token
    always_comb
    begin
        row_len = t_q[ROW_W-1 -: LW];
        row_pc  = t_q[PCW-1:0];
        row_hit = (row_len == tok_len);
        for (int i = 0; i < TOK_MAX; i++)
        begin
            if ((LW'(i) < tok_len) && (t_q[PCW + i*8 +: 8] != tok_text[i*8 +: 8]))
            begin
                row_hit = 1'b0;
            end
        end
        need = (min_len == 5'd0) ? 7'd1 : 7'(min_len);
        pc7  = 7'(row_pc);
        cap7 = (cap_reg > 5'(RESULT_CAP)) ? 7'(RESULT_CAP) : 7'(cap_reg);
        k7   = (pc7 < cap7) ? pc7 : cap7;
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        terms_next  = terms_reg;
        scan_next   = scan_reg;
        idx_next    = idx_reg;
        k_next      = k_reg;
        j_next      = j_reg;
        cap_next    = cap_reg;
        query_next  = query_reg;
        strobe_next = 1'b0;
        hit_next    = hit_reg;
        cnt_next    = cnt_reg;
        total_next  = total_reg;
        fin_next    = fin_reg;
        clr         = 1'b0;
        t_re        = 1'b0;
        t_ra        = scan_reg[AW-1:0];
        t_we        = 1'b0;
        t_wa        = idx_reg;
        t_wd        = {t_q[ROW_W-1:PCW], row_pc + 1'b1};
        p_re        = 1'b0;
        p_ra        = paddr(idx_reg, 7'(j_reg));
        p_we        = 1'b0;
        p_wa        = paddr(idx_reg, 7'(row_pc));
        p_wd        = line;
        case (state_reg)
            S_IDLE:
            begin
                if (job.go)
                begin
                    query_next = job.query;
                    cap_next   = job.cap;
                    scan_next  = '0;
                    if (!job.query && (7'(tok_len) < need))
                    begin
                        clr = 1'b1;
                    end
                    else if (terms_reg == '0)
                    begin
                        state_next = S_MISS;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                t_re       = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (row_hit)
                begin
                    idx_next   = scan_reg[AW-1:0];
                    state_next = S_HIT;
                end
                else if (scan_reg + 1'b1 == terms_reg)
                begin
                    state_next = S_MISS;
                end
                else
                begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_HIT:
            begin
                if (query_reg)
                begin
                    if (k7 == 7'd0)
                    begin
                        strobe_next = 1'b1;
                        hit_next    = '0;
                        cnt_next    = '0;
                        total_next  = 8'(terms_reg);
                        fin_next    = 1'b1;
                        clr         = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        k_next     = 5'(k7);
                        j_next     = '0;
                        state_next = S_ORD;
                    end
                end
                else if (row_pc == '0)
                begin
                    p_we       = 1'b1;
                    t_we       = 1'b1;
                    clr        = 1'b1;
                    state_next = S_IDLE;
                end
                else if (pc7 >= 7'(POSTING_SLOTS))
                begin
                    clr        = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    p_re       = 1'b1;
                    p_ra       = paddr(idx_reg, pc7 - 7'd1);
                    state_next = S_PCHK;
                end
            end
            S_PCHK:
            begin
                if (p_q != line)
                begin
                    p_we = 1'b1;
                    t_we = 1'b1;
                end
                clr        = 1'b1;
                state_next = S_IDLE;
            end
            S_MISS:
            begin
                if (query_reg)
                begin
                    strobe_next = 1'b1;
                    hit_next    = '0;
                    cnt_next    = '0;
                    total_next  = 8'(terms_reg);
                    fin_next    = 1'b1;
                end
                else if (terms_reg < CW'(TERM_SLOTS))
                begin
                    t_we       = 1'b1;
                    t_wa       = terms_reg[AW-1:0];
                    t_wd       = {tok_len, tok_text, PCW'(1)};
                    p_we       = 1'b1;
                    p_wa       = paddr(terms_reg[AW-1:0], 7'd0);
                    terms_next = terms_reg + 1'b1;
                end
                clr        = 1'b1;
                state_next = S_IDLE;
            end
            S_ORD:
            begin
                // read the next slot while delivering the one read before, if any
                if (strobe_reg && !fin_reg && (state_reg == S_ORD) && j_reg != '0)
                begin
                    state_next = S_ORD;
                end
                p_re = 1'b1;
                if (j_reg != '0)
                begin
                    strobe_next = 1'b1;
                    hit_next    = p_q;
                    cnt_next    = k_reg;
                    total_next  = 8'(terms_reg);
                    fin_next    = 1'b0;
                end
                if (j_reg == k_reg)
                begin
                    // last slot already read: deliver it as the final result
                    p_re        = 1'b0;
                    fin_next    = 1'b1;
                    clr         = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            terms_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            terms_reg  <= terms_next;
            strobe_reg <= strobe_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        scan_reg  <= scan_next;
        idx_reg   <= idx_next;
        k_reg     <= k_next;
        j_reg     <= j_next;
        cap_reg   <= cap_next;
        query_reg <= query_next;
        hit_reg   <= hit_next;
        cnt_reg   <= cnt_next;
        total_reg <= total_next;
        fin_reg   <= fin_next;
    end

    // term row memory
    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            tmem[t_wa] <= t_wd;
        end
        if (t_re)
        begin
            t_q <= tmem[t_ra];
        end
    end

    // posting memory
    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            pmem[p_wa] <= p_wd;
        end
        if (p_re)
        begin
            p_q <= pmem[p_ra];
        end
    end

    assign busy        = job.go || (state_reg != S_IDLE);
    assign strobe      = strobe_reg;
    assign hit_line    = hit_reg;
    assign match_count = cnt_reg;
    assign term_total  = total_reg;
    assign final_res   = fin_reg;

endmodule

>>> hw/rtl/inverted_token_index.sv
// Inverted token index. Text characters (op 0) build lowercase alphanumeric
// tokens; at a separator or the final character a token of at least
// min_token_length characters is looked up in the term memory, appended when
// new, and the line id is added to its postings. Query characters (op 1)
// build a term; at the final one its line ids come out on the result ports,
// one per strobe, with final_res on the last, or one empty result on a miss
// or a zero max_lines. A token end walks the stored terms through the
// registered term memory read port, reading then comparing each term, and
// then updates the term and posting memories. A query that hits then reads
// its line ids through the posting memory read port. Results cannot be held
// off; each is shown for exactly one cycle. The term count starts at zero
// after reset, so neither memory needs a clearing pass. Write
// min_token_length only while busy is low.
module inverted_token_index #(
    parameter int TERM_SLOTS    = 128,
    parameter int TERM_BYTES    = 24,
    parameter int POSTING_SLOTS = 16,
    parameter int LINE_ID_BITS  = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    op,
    input  logic [7:0]              ch,
    input  logic                    last,
    input  logic [LINE_ID_BITS-1:0] line_id,
    input  logic [4:0]              max_lines,
    input  logic                    cfg_we,
    input  logic [4:0]              cfg_data,
    output logic                    strobe,
    output logic [LINE_ID_BITS-1:0] hit_line,
    output logic [4:0]              match_count,
    output logic [7:0]              term_total,
    output logic                    final_res
);
    import itx_pkg::*;

    localparam int LW = $clog2(TERM_BYTES);

    logic [4:0]                  min_len_reg;
    itx_job_t                    job;
    logic [LINE_ID_BITS-1:0]     line;
    logic [LW-1:0]               tok_len;
    logic [(TERM_BYTES-1)*8-1:0] tok_text;
    logic                        clr;

    // minimum token length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= 5'd2;
        end
        else if (cfg_we)
        begin
            min_len_reg <= cfg_data;
        end
    end

    itx_tokbuf #(
        .TERM_BYTES   (TERM_BYTES),
        .LINE_ID_BITS (LINE_ID_BITS)
    ) u_tokbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (start && !busy),
        .op        (op),
        .ch        (ch),
        .last      (last),
        .line_id   (line_id),
        .max_lines (max_lines),
        .clr       (clr),
        .job       (job),
        .line      (line),
        .tok_len   (tok_len),
        .tok_text  (tok_text)
    );

    itx_engine #(
        .TERM_SLOTS    (TERM_SLOTS),
        .TERM_BYTES    (TERM_BYTES),
        .POSTING_SLOTS (POSTING_SLOTS),
        .LINE_ID_BITS  (LINE_ID_BITS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .min_len     (min_len_reg),
        .job         (job),
        .line        (line),
        .tok_len     (tok_len),
        .tok_text    (tok_text),
        .busy        (busy),
        .clr         (clr),
        .strobe      (strobe),
        .hit_line    (hit_line),
        .match_count (match_count),
        .term_total  (term_total),
        .final_res   (final_res)
    );

endmodule

>>> hw/rtl/itx_checker.sv
`include "assert_macros.svh"

module itx_checker #(
    parameter int LINE_ID_BITS = 16
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    busy,
    input logic                    strobe,
    input logic [LINE_ID_BITS-1:0] hit_line,
    input logic [4:0]              match_count,
    input logic                    final_res
);

    // a query never returns more than sixteen line ids
    `ASSERT_IMPL(a_count_cap, strobe, match_count <= 5'd16)
    // an empty result is always the final one and carries no line id
    `ASSERT_IMPL(a_empty_final, strobe && (match_count == 5'd0), final_res && (hit_line == '0))
    // while more results of a query are due the block stays busy
    `ASSERT_IMPL(a_busy_pending, strobe && !final_res, busy)
    // nothing follows the final result of a query at once
    `ASSERT_NEXT(a_final_gap, strobe && final_res, !strobe)

endmodule

bind inverted_token_index itx_checker #(.LINE_ID_BITS(LINE_ID_BITS)) u_itx_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .busy        (busy),
    .strobe      (strobe),
    .hit_line    (hit_line),
    .match_count (match_count),
    .final_res   (final_res)
);

>>> tb/sv/inverted_token_index_test.sv
module inverted_token_index_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  TERM_SLOTS = 128;
    localparam int  TOK_MAX    = 23;
    localparam int  POST_SLOTS = 16;
    localparam int  SETTLE     = 300;
    localparam int  LIMIT      = 600000;
    localparam bit  OP_INDEX   = 1'b0;
    localparam bit  OP_QUERY   = 1'b1;

    typedef enum logic [1:0] {K_CHAR, K_CFG, K_DRAIN} entry_kind_t;

    typedef struct {
        entry_kind_t kind;
        logic        op;
        logic [7:0]  ch;
        logic        last;
        logic [15:0] line;
        logic [4:0]  cap;
        logic [4:0]  cfg;
    } entry_t;

    typedef struct {
        logic [15:0] hit;
        logic [4:0]  cnt;
        logic [7:0]  total;
        logic        fin;
    } hit_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        op = 1'b0;
    logic [7:0]  ch = 8'h01;
    logic        last = 1'b0;
    logic [15:0] line_id = '0;
    logic [4:0]  max_lines = '0;
    logic        cfg_we = 1'b0;
    logic [4:0]  cfg_data = '0;
    logic        strobe;
    logic [15:0] hit_line;
    logic [4:0]  match_count;
    logic [7:0]  term_total;
    logic        final_res;

    inverted_token_index dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .op(op), .ch(ch), .last(last), .line_id(line_id), .max_lines(max_lines),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .strobe(strobe), .hit_line(hit_line), .match_count(match_count),
        .term_total(term_total), .final_res(final_res)
    );

    always #1 clk = ~clk;

    // mirror of the index state
    logic [7:0]  idx_text [TERM_SLOTS][TOK_MAX];
    int          idx_len [TERM_SLOTS];
    logic [15:0] idx_post [TERM_SLOTS][POST_SLOTS];
    int          idx_cnt [TERM_SLOTS];
    int          terms_used;
    logic [7:0]  tok_buf [TOK_MAX];
    int          tok_len;
    int          min_len = 2;

    entry_t pending [$];
    hit_t   hits_due [$];
    int     n_chars;
    int     sent;
    int     quiet;
    int     cycles;
    bit     failed;
    string  words [$];

    function automatic int find_term();
        for (int i = 0; i < terms_used; i++) begin
            if (idx_len[i] == tok_len) begin
                bit same;
                same = 1'b1;
                for (int j = 0; j < tok_len; j++)
                    if (idx_text[i][j] != tok_buf[j]) same = 1'b0;
                if (same) return i;
            end
        end
        return -1;
    endfunction

    function automatic void close_token(logic [15:0] line);
        int need;
        int t;
        need = (min_len == 0) ? 1 : min_len;
        if (tok_len >= need) begin
            t = find_term();
            if (t < 0 && terms_used < TERM_SLOTS) begin
                t = terms_used;
                for (int j = 0; j < tok_len; j++) idx_text[t][j] = tok_buf[j];
                idx_len[t] = tok_len;
                terms_used++;
            end
            if (t >= 0 && idx_cnt[t] < POST_SLOTS &&
                (idx_cnt[t] == 0 || idx_post[t][idx_cnt[t]-1] != line)) begin
                idx_post[t][idx_cnt[t]] = line;
                idx_cnt[t]++;
            end
        end
        tok_len = 0;
    endfunction

    // advance the mirror by one accepted item and queue expected hits
    function automatic void index_step(entry_t e);
        logic [7:0] c;
        bit up;
        int t;
        int k;
        int cap;
        hit_t h;
        c = e.ch;
        up = (c >= "A" && c <= "Z");
        if (e.op == OP_INDEX) begin
            if ((c >= "a" && c <= "z") || up || (c >= "0" && c <= "9")) begin
                if (tok_len < TOK_MAX) begin
                    tok_buf[tok_len] = up ? c + 8'd32 : c;
                    tok_len++;
                end
            end else
                close_token(e.line);
            if (e.last) close_token(e.line);
            return;
        end
        if (tok_len < TOK_MAX) begin
            tok_buf[tok_len] = up ? c + 8'd32 : c;
            tok_len++;
        end
        if (!e.last) return;
        cap = (e.cap > 5'd16) ? 16 : int'(e.cap);
        t = find_term();
        tok_len = 0;
        k = 0;
        if (t >= 0) k = (idx_cnt[t] > cap) ? cap : idx_cnt[t];
        h.total = terms_used[7:0];
        if (k == 0) begin
            h.hit = '0;
            h.cnt = '0;
            h.fin = 1'b1;
            hits_due.push_back(h);
        end
        for (int j = 0; j < k; j++) begin
            h.hit = idx_post[t][j];
            h.cnt = k[4:0];
            h.fin = (j == k - 1);
            hits_due.push_back(h);
        end
    endfunction

    // driver: one item per handshake, config writes only when quiet
    always @(posedge clk) begin
        entry_t e;
        bit nstart;
        bit nwe;
        int idle_pct;
        nstart = start;
        nwe = 1'b0;
        if (rst_n) begin
            if (start && !busy) begin
                index_step('{K_CHAR, op, ch, last, line_id, max_lines, 5'd0});
                sent++;
                nstart = 1'b0;
            end
            if (hits_due.size() == 0 && !busy && !nstart && !start)
                quiet++;
            else
                quiet = 0;
            if (!nstart && pending.size() > 0) begin
                e = pending[0];
                idle_pct = (sent < n_chars / 3) ? 11 : (sent < 2 * n_chars / 3) ? 87 : 0;
                if (e.kind != K_CHAR) begin
                    if (quiet >= SETTLE) begin
                        void'(pending.pop_front());
                        quiet = 0;
                        if (e.kind == K_CFG) begin
                            nwe = 1'b1;
                            cfg_data <= e.cfg;
                            min_len = int'(e.cfg);
                        end
                    end
                end else if ($urandom_range(99) >= idle_pct) begin
                    void'(pending.pop_front());
                    nstart = 1'b1;
                    op <= e.op;
                    ch <= e.ch;
                    last <= e.last;
                    line_id <= e.line;
                    max_lines <= e.cap;
                end
            end
        end
        start <= nstart;
        cfg_we <= nwe;
    end

    // monitor: every strobe must match the oldest expected hit
    always @(posedge clk) begin
        hit_t h;
        if (rst_n && strobe) begin
            if (hits_due.size() == 0) begin
                $display("%0t unexpected result: got hit %0d count %0d total %0d final %0b",
                         $time, hit_line, match_count, term_total, final_res);
                failed = 1'b1;
            end else begin
                h = hits_due.pop_front();
                if (hit_line !== h.hit || match_count !== h.cnt ||
                    term_total !== h.total || final_res !== h.fin) begin
                    $display("%0t result mismatch: expected hit %0d count %0d total %0d final %0b",
                             $time, h.hit, h.cnt, h.total, h.fin);
                    $display("%0t                   actual hit %0d count %0d total %0d final %0b",
                             $time, hit_line, match_count, term_total, final_res);
                    failed = 1'b1;
                end
            end
        end
    end

    // run limit
    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic add_char(logic o, logic [7:0] c, logic l, logic [15:0] ln, logic [4:0] cp);
        pending.push_back('{K_CHAR, o, c, l, ln, cp, 5'd0});
        n_chars++;
    endtask

    task automatic add_text(logic o, string s, logic [15:0] ln, logic [4:0] cp);
        for (int i = 0; i < s.len(); i++)
            add_char(o, s[i], i == s.len() - 1, ln, cp);
    endtask

    task automatic add_cfg(logic [4:0] v);
        pending.push_back('{K_CFG, 1'b0, 8'h01, 1'b0, 16'd0, 5'd0, v});
    endtask

    function automatic string rand_word(int n);
        string s;
        string pool;
        pool = "abcdAB0129";
        s = "";
        for (int i = 0; i < n; i++) begin
            s = {s, "x"};
            s[i] = pool[$urandom_range(pool.len() - 1)];
        end
        return s;
    endfunction

    function automatic logic [7:0] rand_sep();
        logic [7:0] c;
        do c = 8'($urandom_range(255, 1));
        while ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9"));
        return c;
    endfunction

    // case-scrambled copy of a stored word
    function automatic string mix_case(string s);
        for (int i = 0; i < s.len(); i++)
            if (s[i] >= "a" && s[i] <= "z" && $urandom_range(1)) s[i] = s[i] - 8'd32;
        return s;
    endfunction

    initial begin
        string s;
        string w;
        logic [15:0] ln;
        int r;
        int nw;
        bit cfg3_done;
        bit cfg1_done;
        n_chars = 0;
        cfg3_done = 1'b0;
        cfg1_done = 1'b0;
        // directed: mixed case, separators, extreme ids and caps
        add_text(OP_INDEX, "Hello, World9", 16'hFFFF, 5'd0);
        add_text(OP_INDEX, "a", 16'h0000, 5'd0);
        add_text(OP_INDEX, "hello", 16'h0000, 5'd0);
        add_text(OP_QUERY, "hello", 16'h0000, 5'd16);
        add_text(OP_QUERY, "WORLD9", 16'h0000, 5'd0);
        add_text(OP_QUERY, "zz", 16'h0000, 5'd31);
        add_char(OP_QUERY, 8'hFF, 1'b1, 16'h0000, 5'd1);
        // shortest and longest qualifying lengths, truncation of long tokens
        add_cfg(5'd23);
        add_text(OP_INDEX, "abcdefghij0123456789xyzQ", 16'h1234, 5'd0);
        add_text(OP_INDEX, "short", 16'h1234, 5'd0);
        add_text(OP_QUERY, "abcdefghij0123456789XYZ", 16'h0, 5'd3);
        add_cfg(5'd0);
        add_text(OP_INDEX, "q!", 16'h0042, 5'd0);
        add_text(OP_QUERY, "q", 16'h0, 5'd2);
        add_cfg(5'd31);
        add_text(OP_INDEX, "no x", 16'h0042, 5'd0);
        add_cfg(5'd1);

        // full postings: one word on seventeen lines, with a repeated line
        for (int i = 0; i < 17; i++)
            add_text(OP_INDEX, (i == 0) ? "pp pp" : "pp", i[15:0] * 16'd3 + 16'd7, 5'd0);
        add_text(OP_QUERY, "PP", 16'h0, 5'd20);
        add_text(OP_QUERY, "pp", 16'h0, 5'd5);
        pending.push_back('{K_DRAIN, 1'b0, 8'h01, 1'b0, 16'd0, 5'd0, 5'd0});

        // random phase: text lines, queries and stray items
        add_cfg(5'd2);
        r = 0;
        while (r < 20) begin
            if (r >= 6 && !cfg3_done) begin
                add_cfg(5'd3);
                cfg3_done = 1'b1;
            end
            if (r >= 13 && !cfg1_done) begin
                add_cfg(5'd1);
                cfg1_done = 1'b1;
            end
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: begin
                    ln = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(3));
                    nw = $urandom_range(3, 1);
                    s = "";
                    for (int i = 0; i < nw; i++) begin
                        w = rand_word($urandom_range(4, 1));
                        words.push_back(w.tolower());
                        s = {s, w, "x"};
                        s[s.len() - 1] = rand_sep();
                    end
                    if ($urandom_range(1)) s = s.substr(0, s.len() - 2);
                    add_text(OP_INDEX, s, ln, 5'd0);
                    r += s.len();
                end
                6, 7, 8: begin
                    if (words.size() > 0 && $urandom_range(3) != 0)
                        w = mix_case(words[$urandom_range(words.size() - 1)]);
                    else
                        w = rand_word($urandom_range(3, 1));
                    add_text(OP_QUERY, w, 16'($urandom), 5'($urandom));
                    r += w.len();
                end
                default: begin
                    add_char(1'($urandom_range(1)), 8'($urandom_range(255, 1)),
                             1'($urandom_range(1)), 16'($urandom), 5'($urandom));
                    r++;
                end
            endcase
        end
        // clear any partial token left by stray items
        add_char(OP_QUERY, "z", 1'b1, 16'h0, 5'd1);
        pending.push_back('{K_DRAIN, 1'b0, 8'h01, 1'b0, 16'd0, 5'd0, 5'd0});

        // hold reset, then wait for the driver to drain and the last results to land
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending.size() == 0 && hits_due.size() == 0 && !start);
        repeat (SETTLE) @(posedge clk);
        if (!failed && hits_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
